/* rtl/isotp_boot_request_receiver_top_assert.svh */
// Assertion macros shared by the receiver modules. Each macro expects clk and
// rst_n to be visible in the module that uses it.
`ifndef ISOTP_BOOT_REQUEST_RECEIVER_TOP_ASSERT_SVH
`define ISOTP_BOOT_REQUEST_RECEIVER_TOP_ASSERT_SVH

`ifndef SYNTH

// Same-cycle implication, checked out of reset only.
`define ISOTP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("isotp receiver assertion failed");

// Next-cycle implication, checked out of reset only.
`define ISOTP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("isotp receiver assertion failed");

`else

`define ISOTP_ASSERT_IMP(lbl, ante, cons)
`define ISOTP_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

/* rtl/isotp_pkg.sv */
`timescale 1ns / 1ps

package isotp_pkg;

  // Received frame types.
  localparam logic [3:0] FT_SINGLE = 4'd0;
  localparam logic [3:0] FT_FIRST  = 4'd1;
  localparam logic [3:0] FT_CONSEC = 4'd2;

  // Response frame types.
  localparam logic [1:0] RT_FIRST  = 2'd1;
  localparam logic [1:0] RT_CONSEC = 2'd2;
  localparam logic [1:0] RT_FLOW   = 2'd3;

  // Configuration register indexes.
  localparam logic CFG_START_ADDR = 1'b0;
  localparam logic CFG_END_ADDR   = 1'b1;

  // Length of the app-size request.
  localparam int REQ_LEN = 11;

  // Queued response entries.
  typedef enum logic [2:0] {
    ENT_FLOW  = 3'd0,
    ENT_RESP1 = 3'd1,
    ENT_RESP2 = 3'd2,
    ENT_RESP3 = 3'd3,
    ENT_RESET = 3'd4
  } entry_t;

  // One entry handed from the front end to the buffer.
  typedef struct packed {
    logic   valid;
    entry_t entry;
  } push_t;

  // Buffer status seen by the top level and the back end.
  typedef struct packed {
    logic full;
    logic valid;
  } buf_stat_t;

  // One result beat.
  typedef struct packed {
    logic            reset_request;
    logic [1:0]      resp_type;
    logic [3:0]      resp_code;
    logic [6:0][7:0] resp_bytes;
  } resp_t;

  // Expected byte j of the app-size request.
  function automatic logic [7:0] req_byte(input int j);
    logic [7:0] b;
    b = 8'h00;
    if (j == 0) begin
      b = 8'h0B;
    end else if (j == 1) begin
      b = 8'h08;
    end
    return b;
  endfunction

endpackage

/* rtl/isotp_rx_front.sv */
`timescale 1ns / 1ps
`include "isotp_boot_request_receiver_top_assert.svh"

module isotp_rx_front #(
  parameter int QUEUE_DEPTH = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  accept_i,
  input  logic                  command_i,
  input  logic [3:0]            frame_type_i,
  input  logic [3:0]            frame_code_i,
  input  logic [6:0][7:0]       data_i,
  output isotp_pkg::push_t      push_o
);
  import isotp_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);

  logic [11:0]   len_r, len_nxt;
  logic [11:0]   rcvd_r, rcvd_nxt;
  logic [3:0]    seq_r, seq_nxt;
  logic [PW-1:0] wr_r, wr_nxt;
  logic [PW-1:0] rd_r, rd_nxt;
  entry_t        q_r [QUEUE_DEPTH];
  entry_t        q_nxt [QUEUE_DEPTH];
  logic [REQ_LEN-1:0] match_r, match_nxt;

  logic          is_sf, is_ff, is_cf, seq_ok;
  logic          start, copying, done, msg_hit, pop_any;
  logic [11:0]   base, rem, off;
  logic [2:0]    avail, n, first;

  function automatic logic [PW-1:0] ring_inc(input logic [PW-1:0] p);
    return (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    is_sf  = command_i && (frame_type_i == FT_SINGLE);
    is_ff  = command_i && (frame_type_i == FT_FIRST);
    is_cf  = command_i && (frame_type_i == FT_CONSEC);
    seq_ok = (frame_code_i == seq_r);

    if (is_sf) begin
      len_nxt = {8'h00, frame_code_i};
    end else if (is_ff) begin
      len_nxt = {frame_code_i, data_i[0]};
    end else begin
      len_nxt = len_r;
    end

    // A zero length only updates the length and starts nothing.
    start   = (is_sf || is_ff) && (len_nxt != 12'd0);
    copying = start || (is_cf && seq_ok);
    base    = start ? 12'd0 : rcvd_r;
    first   = is_ff ? 3'd1 : 3'd0;
    avail   = is_ff ? 3'd6 : 3'd7;
    rem     = len_nxt - base;

    if (copying && (base < len_nxt)) begin
      n = (rem < {9'd0, avail}) ? rem[2:0] : avail;
    end else begin
      n = 3'd0;
    end

    rcvd_nxt = copying ? base + {9'd0, n} : rcvd_r;
    done     = copying && (rcvd_nxt == len_nxt);

    if (is_ff && start) begin
      seq_nxt = 4'd1;
    end else if (is_cf) begin
      if (seq_ok) begin
        seq_nxt = (seq_r == 4'd15) ? 4'd1 : seq_r + 4'd1;
      end else begin
        seq_nxt = 4'd0;
      end
    end else begin
      seq_nxt = seq_r;
    end

    // Only the first bytes of a message can take part in the request match,
    // so a per-byte match flag stands in for the stored byte.
    off = 12'd0;
    for (int j = 0; j < REQ_LEN; j++) begin
      match_nxt[j] = match_r[j];
      off = 12'(j) - base;
      if (copying && (12'(j) >= base) && (off < {9'd0, n})) begin
        match_nxt[j] = (data_i[off[2:0] + first] == req_byte(j));
      end
    end

    msg_hit = done && (len_nxt == 12'(REQ_LEN)) && (&match_nxt);

    // Pushes in order: flow control first, then the request responses.
    q_nxt  = q_r;
    wr_nxt = wr_r;
    if (is_ff && start) begin
      q_nxt[wr_nxt] = ENT_FLOW;
      wr_nxt = ring_inc(wr_nxt);
    end
    if (msg_hit) begin
      q_nxt[wr_nxt] = ENT_RESP1;
      wr_nxt = ring_inc(wr_nxt);
      q_nxt[wr_nxt] = ENT_RESP2;
      wr_nxt = ring_inc(wr_nxt);
      q_nxt[wr_nxt] = ENT_RESP3;
      wr_nxt = ring_inc(wr_nxt);
      q_nxt[wr_nxt] = ENT_RESET;
      wr_nxt = ring_inc(wr_nxt);
    end

    pop_any      = (rd_r != wr_nxt);
    rd_nxt       = pop_any ? ring_inc(rd_r) : rd_r;
    push_o.valid = accept_i && pop_any;
    push_o.entry = q_nxt[rd_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r  <= '0;
      rcvd_r <= '0;
      seq_r  <= '0;
      wr_r   <= '0;
      rd_r   <= '0;
    end else if (accept_i) begin
      len_r  <= len_nxt;
      rcvd_r <= rcvd_nxt;
      seq_r  <= seq_nxt;
      wr_r   <= wr_nxt;
      rd_r   <= rd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept_i) begin
      q_r     <= q_nxt;
      match_r <= match_nxt;
    end
  end

  `ISOTP_ASSERT_NXT(a_seq_clear, accept_i && is_cf && !seq_ok, seq_r == 4'd0)
  `ISOTP_ASSERT_NXT(a_rcvd_step, accept_i && is_cf && seq_ok, (rcvd_r - $past(rcvd_r)) <= 12'd7)

endmodule

/* rtl/isotp_rx_fifo.sv */
`timescale 1ns / 1ps
`include "isotp_boot_request_receiver_top_assert.svh"

module isotp_rx_fifo (
  input  logic                  clk,
  input  logic                  rst_n,
  input  isotp_pkg::push_t      push_i,
  input  logic                  pop_i,
  output isotp_pkg::buf_stat_t  stat_o,
  output isotp_pkg::entry_t     entry_o
);
  import isotp_pkg::*;

  // Two entries let the front and back ends run at full rate while the output
  // flows; an output stall can fill the buffer and so raise its full flag.
  entry_t     mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       do_pop;

  assign stat_o.full  = (cnt_r == 2'd2);
  assign stat_o.valid = (cnt_r != 2'd0);
  assign entry_o      = mem_r[rp_r];
  assign do_pop       = pop_i && stat_o.valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push_i.valid) begin
        wp_r <= ~wp_r;
      end
      if (do_pop) begin
        rp_r <= ~rp_r;
      end
      if (push_i.valid && !do_pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (!push_i.valid && do_pop) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push_i.valid) begin
      mem_r[wp_r] <= push_i.entry;
    end
  end

  `ISOTP_ASSERT_IMP(a_no_overrun, push_i.valid, !stat_o.full)

endmodule

/* rtl/isotp_rx_back.sv */
`timescale 1ns / 1ps
`include "isotp_boot_request_receiver_top_assert.svh"

module isotp_rx_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  buf_valid_i,
  input  isotp_pkg::entry_t     entry_i,
  output logic                  buf_pop_o,
  input  logic                  cfg_write_i,
  input  logic                  cfg_index_i,
  input  logic [31:0]           cfg_data_i,
  input  logic                  out_stall_i,
  output logic                  out_valid_o,
  output isotp_pkg::resp_t      beat_o
);
  import isotp_pkg::*;

  logic [15:0] start_addr_r;
  logic [31:0] end_addr_r;
  logic        out_valid_r;
  resp_t       beat_r, beat_nxt;
  logic        load;

  assign load        = buf_valid_i && (!out_valid_r || !out_stall_i);
  assign buf_pop_o   = load;
  assign out_valid_o = out_valid_r;
  assign beat_o      = beat_r;

  always_comb begin
    beat_nxt = '0;
    unique case (entry_i)
      ENT_FLOW: begin
        beat_nxt.resp_type  = RT_FLOW;
        beat_nxt.resp_bytes = {8'h55, 8'h55, 8'h55, 8'h55, 8'h55, 8'h01, 8'h00};
      end
      ENT_RESP1: begin
        beat_nxt.resp_type  = RT_FIRST;
        beat_nxt.resp_bytes = {8'h00, 8'h00, 8'h00, 8'h00, 8'h08, 8'h0B, 8'h14};
      end
      ENT_RESP2: begin
        beat_nxt.resp_type  = RT_CONSEC;
        beat_nxt.resp_code  = 4'd1;
        beat_nxt.resp_bytes = {8'h00, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
      end
      ENT_RESP3: begin
        beat_nxt.resp_type  = RT_CONSEC;
        beat_nxt.resp_code  = 4'd2;
        beat_nxt.resp_bytes = {end_addr_r[31:24], end_addr_r[23:16], end_addr_r[15:8],
                               end_addr_r[7:0], 8'h00, start_addr_r[7:0],
                               start_addr_r[15:8]};
      end
      default: begin
        beat_nxt.reset_request = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_addr_r <= '0;
      end_addr_r   <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_write_i) begin
        if (cfg_index_i == CFG_START_ADDR) begin
          start_addr_r <= cfg_data_i[15:0];
        end else begin
          end_addr_r <= cfg_data_i;
        end
      end
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      beat_r <= beat_nxt;
    end
  end

  `ISOTP_ASSERT_NXT(a_out_fills, buf_valid_i && !out_valid_r, out_valid_r)

endmodule

/* rtl/isotp_boot_request_receiver_top.sv */
`timescale 1ns / 1ps

// ISO-TP style boot request receiver. Each beat on the in_ channel may carry
// one received CAN frame (single, first or consecutive); the block reassembles
// the message, answers a first frame with flow control and, when the complete
// message is exactly the 11-byte app-size request, queues three response
// frames followed by a reset request. Every accepted input beat hands out at
// most one queued response, in order, on the out_ channel; a beat with
// in_command low is a poll that only drains the response queue. The block
// takes one input beat per clock cycle while in_stall is low. The front end
// updates the reassembly state and the response ring in a single step and
// hands a released response on through the buffer to the output register of
// the back end. A two-entry buffer sits between the front and back ends, and
// in_stall is raised only while that buffer is full, which can happen when
// out_stall holds a response waiting at the output.
// The app start and end addresses are written through the cfg_ port, which
// is always ready; they should only change while no response is in flight.
// The response ring holds QUEUE_DEPTH entries and, like the protocol stack it
// mirrors, overwrites old entries without a full check.
module isotp_boot_request_receiver_top #(
  parameter int QUEUE_DEPTH = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_command,
  input  logic [3:0]  in_frame_type,
  input  logic [3:0]  in_frame_code,
  input  logic [7:0]  in_data_byte1,
  input  logic [7:0]  in_data_byte2,
  input  logic [7:0]  in_data_byte3,
  input  logic [7:0]  in_data_byte4,
  input  logic [7:0]  in_data_byte5,
  input  logic [7:0]  in_data_byte6,
  input  logic [7:0]  in_data_byte7,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_reset_request,
  output logic [1:0]  out_resp_type,
  output logic [3:0]  out_resp_code,
  output logic [7:0]  out_resp_byte1,
  output logic [7:0]  out_resp_byte2,
  output logic [7:0]  out_resp_byte3,
  output logic [7:0]  out_resp_byte4,
  output logic [7:0]  out_resp_byte5,
  output logic [7:0]  out_resp_byte6,
  output logic [7:0]  out_resp_byte7,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);
  import isotp_pkg::*;

  logic            accept;
  logic [6:0][7:0] data;
  push_t           push;
  buf_stat_t       stat;
  entry_t          head;
  logic            buf_pop;
  resp_t           beat;

  // The buffer status is registered, so in_stall never depends on in_valid.
  assign in_stall  = stat.full;
  assign accept    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  assign data = {in_data_byte7, in_data_byte6, in_data_byte5, in_data_byte4,
                 in_data_byte3, in_data_byte2, in_data_byte1};

  // Front end: reassembly, request match and the response ring.
  isotp_rx_front #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept_i     (accept),
    .command_i    (in_command),
    .frame_type_i (in_frame_type),
    .frame_code_i (in_frame_code),
    .data_i       (data),
    .push_o       (push)
  );

  // Decoupling buffer between the two halves.
  isotp_rx_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (push),
    .pop_i   (buf_pop),
    .stat_o  (stat),
    .entry_o (head)
  );

  // Back end: address registers, response formatting and the output beat.
  isotp_rx_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .buf_valid_i (stat.valid),
    .entry_i     (head),
    .buf_pop_o   (buf_pop),
    .cfg_write_i (cfg_valid && cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .out_stall_i (out_stall),
    .out_valid_o (out_valid),
    .beat_o      (beat)
  );

  assign out_reset_request = beat.reset_request;
  assign out_resp_type     = beat.resp_type;
  assign out_resp_code     = beat.resp_code;
  assign out_resp_byte1    = beat.resp_bytes[0];
  assign out_resp_byte2    = beat.resp_bytes[1];
  assign out_resp_byte3    = beat.resp_bytes[2];
  assign out_resp_byte4    = beat.resp_bytes[3];
  assign out_resp_byte5    = beat.resp_bytes[4];
  assign out_resp_byte6    = beat.resp_bytes[5];
  assign out_resp_byte7    = beat.resp_bytes[6];

endmodule
